@@ rtl/core/icaf_pkg.sv @@
`timescale 1ns / 1ps
// icaf_pkg: shared types, widths, constants and the atan table for the imu attitude filter
// no dependencies; imported by every module of the block

package icaf_pkg;

    localparam int CAL_SAMPLES  = 20;
    localparam int CORDIC_STEPS = 16;

    localparam int RAW_W   = 16;
    localparam int SUM_W   = 21;
    localparam int OFS_W   = 22;
    localparam int CORR_W  = 23;
    localparam int ANG_W   = 24;
    localparam int STEP_W  = 28;
    localparam int OUT_W   = 32;
    localparam int DIVD_W  = 34;
    localparam int DIVR_W  = 24;
    localparam int CORD_W  = 41;
    localparam int CACC_W  = 25;
    localparam int ACC_W   = 52;
    localparam int TAB_IW  = 5;
    localparam int CAL_CW  = $clog2(CAL_SAMPLES + 1);
    localparam int DIV_CW  = $clog2(DIVD_W);

    localparam logic [16:0] UNITY      = 17'd65536;
    localparam logic [23:0] STEP_SCALE = 24'd131;
    localparam logic [23:0] CAL_DIV    = 24'(CAL_SAMPLES);
    localparam logic signed [ANG_W-1:0] RIGHT_ANGLE = 24'sd5898240;
    localparam logic signed [OFS_W-1:0] ONE_G_OFS   = 22'sd262144;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    localparam logic [1:0] REG_ACCEL_WEIGHT  = 2'd0;
    localparam logic [1:0] REG_YAW_GAIN      = 2'd1;
    localparam logic [1:0] REG_GYRO_STEP_DIV = 2'd2;

    localparam logic [16:0] RST_ACCEL_WEIGHT  = 17'd62259;
    localparam logic [16:0] RST_YAW_GAIN      = 17'd58982;
    localparam logic [15:0] RST_GYRO_STEP_DIV = 16'd7500;

    typedef struct packed {
        logic signed [RAW_W-1:0] accel_x;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_z;
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] gyro_z;
    } sample_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] pitch_deg;
        logic signed [OUT_W-1:0] roll_deg;
        logic signed [OUT_W-1:0] yaw_deg;
    } angle_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFS,
        ST_OFS_WAIT,
        ST_STEP,
        ST_STEP_WAIT,
        ST_ATAN,
        ST_ATAN_WAIT,
        ST_MUL_A,
        ST_MUL_B,
        ST_YAW_MUL,
        ST_YAW_SUM,
        ST_DONE
    } icaf_state_t;

    // atan(2^-i) in degrees, q16
    function automatic logic signed [CACC_W-1:0] atan_tab(input logic [TAB_IW-1:0] i);
        logic signed [CACC_W-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/icaf_div.sv @@
`timescale 1ns / 1ps
// icaf_div: bit-serial restoring divider, rounds to nearest with ties away from zero
// depends on icaf_pkg

module icaf_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [icaf_pkg::DIVD_W-1:0]       mag,
    input  logic                              neg,
    input  logic [icaf_pkg::DIVR_W-1:0]       divisor,
    output logic                              done,
    output logic signed [icaf_pkg::STEP_W-1:0] quot
);
    import icaf_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic [DIVD_W-1:0]   num_reg;
    logic [DIVR_W-1:0]   rem_reg;
    logic [DIVR_W-1:0]   d_reg;
    logic                neg_reg;
    logic [DIVR_W:0]     shifted;
    logic                qbit;
    logic [DIVR_W-1:0]   rem_next;
    logic [STEP_W-1:0]   q;

    always_comb
    begin
        shifted  = {rem_reg, num_reg[DIVD_W-1]};
        qbit     = (shifted >= {1'b0, d_reg});
        rem_next = qbit ? DIVR_W'(shifted - {1'b0, d_reg}) : DIVR_W'(shifted);
        q        = num_reg[STEP_W-1:0];
        quot     = neg_reg ? -signed'(q) : signed'(q);
        done     = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIVD_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= mag + DIVD_W'(divisor >> 1);
            d_reg   <= divisor;
            rem_reg <= '0;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIVD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

endmodule

@@ rtl/core/icaf_cordic.sv @@
`timescale 1ns / 1ps
// icaf_cordic: iterative vectoring cordic, one rotation per cycle, angle in q16 degrees
// depends on icaf_pkg

module icaf_cordic (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [icaf_pkg::CORR_W-1:0] num,
    input  logic signed [icaf_pkg::CORR_W-1:0] den,
    output logic                              done,
    output logic signed [icaf_pkg::ANG_W-1:0]  ang
);
    import icaf_pkg::*;

    logic                       busy_reg;
    logic                       done_reg;
    logic [TAB_IW-1:0]          cnt_reg;
    logic signed [CORD_W-1:0]   x_reg;
    logic signed [CORD_W-1:0]   y_reg;
    logic signed [CACC_W-1:0]   acc_reg;
    logic                       neg_reg;
    logic                       spec_reg;
    logic signed [ANG_W-1:0]    spec_ang_reg;
    logic [CORR_W-1:0]          num_abs;
    logic [CORR_W-1:0]          den_abs;
    logic signed [CORD_W-1:0]   xs;
    logic signed [CORD_W-1:0]   ys;
    logic signed [ANG_W-1:0]    mag;

    always_comb
    begin
        num_abs = num[CORR_W-1] ? CORR_W'(-num) : CORR_W'(num);
        den_abs = den[CORR_W-1] ? CORR_W'(-den) : CORR_W'(den);
        xs      = x_reg >>> cnt_reg;
        ys      = y_reg >>> cnt_reg;
        if (acc_reg < 0)
            mag = '0;
        else if (acc_reg > CACC_W'(RIGHT_ANGLE))
            mag = RIGHT_ANGLE;
        else
            mag = ANG_W'(acc_reg);
        if (spec_reg)
            ang = spec_ang_reg;
        else
            ang = neg_reg ? -mag : mag;
        done = done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !((den == '0) || (num == '0));
            done_reg <= (den == '0) || (num == '0);
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == TAB_IW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORD_W'(den_abs) <<< 16;
            y_reg    <= CORD_W'(num_abs) <<< 16;
            acc_reg  <= '0;
            neg_reg  <= num[CORR_W-1] != den[CORR_W-1];
            spec_reg <= (den == '0) || (num == '0);
            if (den != '0 || num == '0)
                spec_ang_reg <= '0;
            else
                spec_ang_reg <= num[CORR_W-1] ? -RIGHT_ANGLE : RIGHT_ANGLE;
        end
        else if (busy_reg)
        begin
            if (!y_reg[CORD_W-1])
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + atan_tab(cnt_reg);
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - atan_tab(cnt_reg);
            end
        end
    end

endmodule

@@ rtl/core/imu_complementary_attitude_filter.sv @@
`timescale 1ns / 1ps
// imu_complementary_attitude_filter: top level, calibration, sequencer and angle mixing
// depends on icaf_pkg, icaf_div, icaf_cordic

// One word is taken at a time. The first 20 words only calibrate and give no result;
// the last of them starts six divisions that set the offsets. Each later word passes
// through the bit-serial divider once for each of the three gyro steps, then through
// two cordic passes for pitch and roll, then through mixing, output and handshake.
// A finished result waits in the output register while the next word is taken.
module imu_complementary_attitude_filter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  icaf_pkg::sample_t   sample,
    output logic                angle_valid,
    input  logic                angle_stall,
    output icaf_pkg::angle_t    angle,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data
);
    import icaf_pkg::*;

    icaf_state_t                state_reg;
    icaf_state_t                state_next;
    logic [2:0]                 idx_reg;
    logic [CAL_CW-1:0]          cal_cnt_reg;
    logic signed [SUM_W-1:0]    cal_sum_reg [6];
    logic signed [OFS_W-1:0]    ofs_reg [6];
    logic signed [OUT_W-1:0]    pitch_reg;
    logic signed [OUT_W-1:0]    roll_reg;
    logic signed [OUT_W-1:0]    yaw_reg;
    logic [16:0]                weight_reg;
    logic [16:0]                gain_reg;
    logic [15:0]                sdiv_reg;
    logic                       out_valid_reg;
    angle_t                     out_reg;
    sample_t                    sample_reg;
    logic signed [STEP_W-1:0]   sp_reg [3];
    logic signed [STEP_W-1:0]   fresh_reg [2];
    logic signed [ACC_W-1:0]    acc_reg;

    logic                       accept;
    logic                       out_free;
    logic signed [RAW_W-1:0]    raw_in [6];
    logic signed [RAW_W-1:0]    raw [6];
    logic signed [CORR_W-1:0]   c_val [6];
    logic [15:0]                sdiv_eff;
    logic [16:0]                k_eff;
    logic [16:0]                g_eff;
    logic signed [17:0]         k_s;
    logic signed [17:0]         kc_s;
    logic signed [17:0]         g_s;
    logic signed [STEP_W-1:0]   fresh_sel;
    logic signed [OUT_W-1:0]    prev_sel;
    logic signed [45:0]         prod_a;
    logic signed [49:0]         prod_b;
    logic signed [45:0]         prod_y;
    logic signed [ACC_W-1:0]    mix_sum;
    logic signed [OUT_W:0]      ysum;
    logic signed [CORR_W-1:0]   c_step;
    logic signed [SUM_W-1:0]    sum_sel;
    logic [CORR_W-1:0]          c_abs;
    logic [SUM_W-1:0]           sum_abs;

    logic                       div_start;
    logic [DIVD_W-1:0]          div_mag;
    logic                       div_neg;
    logic [DIVR_W-1:0]          div_d;
    logic                       div_done;
    logic signed [STEP_W-1:0]   div_quot;
    logic                       cor_start;
    logic signed [CORR_W-1:0]   cor_num;
    logic                       cor_done;
    logic signed [ANG_W-1:0]    cor_ang;

    icaf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (div_mag),
        .neg     (div_neg),
        .divisor (div_d),
        .done    (div_done),
        .quot    (div_quot)
    );

    icaf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .num   (cor_num),
        .den   (c_val[2]),
        .done  (cor_done),
        .ang   (cor_ang)
    );

    always_comb
    begin
        raw_in[0] = sample.accel_x;
        raw_in[1] = sample.accel_y;
        raw_in[2] = sample.accel_z;
        raw_in[3] = sample.gyro_x;
        raw_in[4] = sample.gyro_y;
        raw_in[5] = sample.gyro_z;
        raw[0]    = sample_reg.accel_x;
        raw[1]    = sample_reg.accel_y;
        raw[2]    = sample_reg.accel_z;
        raw[3]    = sample_reg.gyro_x;
        raw[4]    = sample_reg.gyro_y;
        raw[5]    = sample_reg.gyro_z;
        for (int i = 0; i < 6; i++)
            c_val[i] = (CORR_W'(raw[i]) <<< 4) + CORR_W'(ofs_reg[i]);
    end

    always_comb
    begin
        sdiv_eff  = (sdiv_reg == '0) ? 16'd1 : sdiv_reg;
        k_eff     = (weight_reg > UNITY) ? UNITY : weight_reg;
        g_eff     = (gain_reg > UNITY) ? UNITY : gain_reg;
        k_s       = signed'({1'b0, k_eff});
        kc_s      = signed'({1'b0, 17'(UNITY - k_eff)});
        g_s       = signed'({1'b0, g_eff});
        fresh_sel = idx_reg[0] ? fresh_reg[1] : fresh_reg[0];
        prev_sel  = idx_reg[0] ? roll_reg : pitch_reg;
        prod_a    = k_s * fresh_sel;
        prod_b    = kc_s * prev_sel;
        prod_y    = g_s * sp_reg[2];
        mix_sum   = acc_reg + ACC_W'(prod_b) + ACC_W'(ROUND_HALF);
        ysum      = (OUT_W+1)'(yaw_reg) + (OUT_W+1)'(acc_reg >>> 16);
        c_step    = c_val[3 + idx_reg[1:0]];
        c_abs     = c_step[CORR_W-1] ? CORR_W'(-c_step) : CORR_W'(c_step);
        sum_sel   = cal_sum_reg[idx_reg];
        sum_abs   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        accept    = sample_valid && !sample_stall;
        out_free  = !out_valid_reg || !angle_stall;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cal_cnt_reg != CAL_CW'(CAL_SAMPLES))
                        state_next = (cal_cnt_reg == CAL_CW'(CAL_SAMPLES - 1)) ? ST_OFS : ST_IDLE;
                    else
                        state_next = ST_STEP;
                end
            end
            ST_OFS:       state_next = ST_OFS_WAIT;
            ST_OFS_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == 3'd5) ? ST_IDLE : ST_OFS;
            end
            ST_STEP:      state_next = ST_STEP_WAIT;
            ST_STEP_WAIT:
            begin
                if (div_done)
                    state_next = (idx_reg == 3'd2) ? ST_ATAN : ST_STEP;
            end
            ST_ATAN:      state_next = ST_ATAN_WAIT;
            ST_ATAN_WAIT:
            begin
                if (cor_done)
                    state_next = (idx_reg == 3'd1) ? ST_MUL_A : ST_ATAN;
            end
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = idx_reg[0] ? ST_YAW_MUL : ST_MUL_A;
            ST_YAW_MUL:   state_next = ST_YAW_SUM;
            ST_YAW_SUM:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        sample_stall = (state_reg != ST_IDLE);
        div_start    = 1'b0;
        div_mag      = '0;
        div_neg      = 1'b0;
        div_d        = CAL_DIV;
        cor_start    = 1'b0;
        cor_num      = idx_reg[0] ? c_val[1] : c_val[0];
        unique case (state_reg)
            ST_OFS:
            begin
                div_start = 1'b1;
                div_mag   = DIVD_W'(sum_abs) << 4;
                div_neg   = sum_sel[SUM_W-1];
                div_d     = CAL_DIV;
            end
            ST_STEP:
            begin
                div_start = 1'b1;
                div_mag   = DIVD_W'(c_abs) << 12;
                div_neg   = c_step[CORR_W-1];
                div_d     = STEP_SCALE * DIVR_W'(sdiv_eff);
            end
            ST_ATAN:
            begin
                cor_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
        angle_valid = out_valid_reg;
        angle       = out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cal_cnt_reg   <= '0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            yaw_reg       <= '0;
            weight_reg    <= RST_ACCEL_WEIGHT;
            gain_reg      <= RST_YAW_GAIN;
            sdiv_reg      <= RST_GYRO_STEP_DIV;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                cal_sum_reg[i] <= '0;
                ofs_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ACCEL_WEIGHT:  weight_reg <= cfg_data;
                    REG_YAW_GAIN:      gain_reg   <= cfg_data;
                    REG_GYRO_STEP_DIV: sdiv_reg   <= cfg_data[15:0];
                    default:           ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!angle_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (accept && cal_cnt_reg != CAL_CW'(CAL_SAMPLES))
                    begin
                        cal_cnt_reg <= cal_cnt_reg + 1'b1;
                        for (int i = 0; i < 6; i++)
                            cal_sum_reg[i] <= cal_sum_reg[i] + SUM_W'(raw_in[i]);
                    end
                end
                ST_OFS_WAIT:
                begin
                    if (div_done)
                    begin
                        ofs_reg[idx_reg] <= OFS_W'(-div_quot)
                                            + ((idx_reg == 3'd2) ? ONE_G_OFS : '0);
                        idx_reg <= (idx_reg == 3'd5) ? 3'd0 : idx_reg + 1'b1;
                    end
                end
                ST_STEP_WAIT:
                begin
                    if (div_done)
                        idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 1'b1;
                end
                ST_ATAN_WAIT:
                begin
                    if (cor_done)
                        idx_reg <= (idx_reg == 3'd1) ? 3'd0 : idx_reg + 1'b1;
                end
                ST_MUL_B:
                begin
                    if (idx_reg[0])
                        roll_reg <= mix_sum[47:16];
                    else
                        pitch_reg <= mix_sum[47:16];
                    idx_reg <= idx_reg[0] ? 3'd0 : 3'd1;
                end
                ST_YAW_SUM:
                begin
                    if (ysum[OUT_W] != ysum[OUT_W-1])
                        yaw_reg <= ysum[OUT_W] ? {1'b1, {(OUT_W-1){1'b0}}}
                                               : {1'b0, {(OUT_W-1){1'b1}}};
                    else
                        yaw_reg <= ysum[OUT_W-1:0];
                end
                default:
                begin
                    idx_reg <= idx_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            sample_reg <= sample;
        if (state_reg == ST_STEP_WAIT && div_done)
            sp_reg[idx_reg[1:0]] <= div_quot;
        if (state_reg == ST_ATAN_WAIT && cor_done)
            fresh_reg[idx_reg[0]] <= STEP_W'(cor_ang) + (idx_reg[0] ? sp_reg[0] : sp_reg[1]);
        if (state_reg == ST_MUL_A)
            acc_reg <= ACC_W'(prod_a);
        if (state_reg == ST_YAW_MUL)
            acc_reg <= ACC_W'(prod_y) + ACC_W'(ROUND_HALF);
        if (state_reg == ST_DONE && out_free)
        begin
            out_reg.pitch_deg <= pitch_reg;
            out_reg.roll_deg  <= roll_reg;
            out_reg.yaw_deg   <= yaw_reg;
        end
    end

endmodule
